### rtl/emboss_shifted_negative_average_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef EMBOSS_SHIFTED_NEGATIVE_AVERAGE_CORE_MACROS_SVH
`define EMBOSS_SHIFTED_NEGATIVE_AVERAGE_CORE_MACROS_SVH

// Checked only while out of reset.
`define ESNA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ESNA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/esna_pkg.sv
`default_nettype none

package esna_pkg;

  localparam logic [7:0] NEG_MAX = 8'd255;
  localparam int unsigned RSEEN_MAX = 15;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH = 2'd0,
    CFG_SHIFT_X     = 2'd1,
    CFG_SHIFT_Y     = 2'd2
  } esna_cfg_idx_t;

  // Per-beat control carried from the front to the back.
  typedef struct packed {
    logic frame_first;  // copy of the frame-start flag
    logic own;          // read hits this beat's own write
  } esna_ctl_t;

endpackage

`default_nettype wire

### rtl/esna_ram.sv
`default_nettype none

module esna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/esna_front.sv
`default_nettype none

module esna_front
  import esna_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int ROW_SLOTS = 16,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int SW = $clog2(ROW_SLOTS),
  localparam int AW = SW + XW
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    pixel,
  input  wire logic          frame_start,
  input  wire logic [10:0]   image_width,
  input  wire logic [3:0]    shift_x,
  input  wire logic [3:0]    shift_y,
  input  wire logic          q_ready,
  output logic               push,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_addr,
  output esna_ctl_t          ctl
);

  localparam int SLOT_MAX = ROW_SLOTS - 1;

  logic [XW-1:0] col_r, col_nxt, cur_col, sx;
  logic [SW-1:0] slot_r, slot_nxt, cur_slot, rd_slot, dy;
  logic [3:0]    seen_r, seen_nxt, cur_seen;
  logic [XW:0]   w_eff;
  logic          row_end;

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  // frame start restarts the raster before this pixel is placed
  assign cur_col  = frame_start ? '0 : col_r;
  assign cur_slot = frame_start ? '0 : slot_r;
  assign cur_seen = frame_start ? '0 : seen_r;

  always_comb begin
    if (image_width == '0) begin
      w_eff = (XW+1)'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (XW+1)'(image_width);
    end
  end

  assign dy = (int'(shift_y) > SLOT_MAX) ? SW'(SLOT_MAX) : SW'(shift_y);

  assign sx = (cur_col >= XW'(shift_x)) ? cur_col - XW'(shift_x) : cur_col;

  always_comb begin
    if (int'(cur_seen) >= int'(dy)) begin
      if (cur_slot >= dy) begin
        rd_slot = cur_slot - dy;
      end else begin
        rd_slot = SW'((SW+1)'(cur_slot) + (SW+1)'(ROW_SLOTS) - (SW+1)'(dy));
      end
    end else begin
      rd_slot = cur_slot;
    end
  end

  assign wr_addr = {cur_slot, cur_col};
  assign rd_addr = {rd_slot, sx};

  assign ctl.frame_first = frame_start;
  assign ctl.own         = (rd_addr == wr_addr);

  assign row_end = ({1'b0, cur_col} + (XW+1)'(1)) >= w_eff;

  always_comb begin
    col_nxt  = cur_col + XW'(1);
    slot_nxt = cur_slot;
    seen_nxt = cur_seen;
    if (row_end) begin
      col_nxt  = '0;
      slot_nxt = (int'(cur_slot) == SLOT_MAX) ? '0 : cur_slot + SW'(1);
      seen_nxt = (int'(cur_seen) == RSEEN_MAX) ? cur_seen : cur_seen + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      slot_r <= '0;
      seen_r <= '0;
    end else if (push) begin
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
      seen_r <= seen_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/esna_queue.sv
`default_nettype none

module esna_queue #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  not_full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic      [WIDTH-1:0] head_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CW-1:0]    cnt_r;

  assign not_full  = (int'(cnt_r) != DEPTH);
  assign not_empty = (cnt_r != '0);
  assign head_data = entry_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (int'(wp_r) == DEPTH - 1) ? '0 : wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= (int'(rp_r) == DEPTH - 1) ? '0 : rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/esna_back.sv
`default_nettype none

module esna_back
  import esna_pkg::*;
#(
  parameter int AW    = 14,
  parameter int DEPTH = 16384
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               pop,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic [7:0]    pixel,
  input  wire esna_ctl_t     ctl,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         embossed,
  output logic               frame_first
);

  logic       s1_v_r;
  logic [7:0] s1_pix_r;
  esna_ctl_t  s1_ctl_r;
  logic [7:0] rdata, neg;
  logic [8:0] sum;
  logic       o_v_r, o_ff_r;
  logic [7:0] o_emb_r;
  logic       o_open, s1_open;

  assign o_open  = !o_v_r || out_ready;
  assign s1_open = !s1_v_r || o_open;
  assign pop     = q_valid && s1_open;

  // write the negative and fetch the shifted one in the same beat
  esna_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (pop),
    .waddr (wr_addr),
    .wdata (NEG_MAX - pixel),
    .re    (pop),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // RAM returns old data on a same-address hit
  assign neg = s1_ctl_r.own ? (NEG_MAX - s1_pix_r) : rdata;
  assign sum = {1'b0, neg} + {1'b0, s1_pix_r};

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_pix_r <= pixel;
      s1_ctl_r <= ctl;
    end
    if (s1_v_r && o_open) begin
      o_emb_r <= sum[8:1];
      o_ff_r  <= s1_ctl_r.frame_first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_v_r <= pop;
      end
      if (o_open) begin
        o_v_r <= s1_v_r;
      end
    end
  end

  assign out_valid   = o_v_r;
  assign embossed    = o_emb_r;
  assign frame_first = o_ff_r;

endmodule

`default_nettype wire

### rtl/emboss_shifted_negative_average_core.sv
// Channel | Dir | Beat contents (low bit first)
// in_     | in  | tdata: pixel[7:0]; tuser: frame_start
// out_    | out | tdata: embossed[7:0]; tuser: frame_first
// cfg_    | in  | write only: 0 image_width, 1 shift_x, 2 shift_y
//
// One beat per clock sustained while out_tready is high; the row store has one write and one read port,
// used once per beat.
// An accepted input beat passes through the queue, the RAM stage and the output register to out_tvalid.
// Up to six beats in flight (four in the queue, RAM stage, output register).
// rst_n is synchronous; counters and valids clear, the row store does not.
// in_tready drops only when the queue is full; out_tready stalls the back end.
`default_nettype none

module emboss_shifted_negative_average_core
  import esna_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int ROW_SLOTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] pixel
  input  wire logic        in_tuser,   // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] embossed
  output logic             out_tuser,  // [0] frame_first
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [10:0] cfg_wdata
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int SW    = $clog2(ROW_SLOTS);
  localparam int AW    = SW + XW;
  localparam int DEPTH = ROW_SLOTS * (2 ** XW);
  localparam int CTLW  = $bits(esna_ctl_t);
  localparam int QW    = 2 * AW + 8 + CTLW;
  localparam int QDEPTH = 4;

  // configuration registers
  logic [10:0] image_width_r;
  logic [3:0]  shift_x_r, shift_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= 11'd256;
      shift_x_r     <= 4'd1;
      shift_y_r     <= 4'd1;
    end else if (cfg_we) begin
      unique case (esna_cfg_idx_t'(cfg_addr))
        CFG_IMAGE_WIDTH: image_width_r <= cfg_wdata;
        CFG_SHIFT_X:     shift_x_r     <= cfg_wdata[3:0];
        CFG_SHIFT_Y:     shift_y_r     <= cfg_wdata[3:0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  // front: raster position, ring slot and both addresses
  logic          push, q_not_full, q_not_empty, pop;
  logic [AW-1:0] f_wr_addr, f_rd_addr, b_wr_addr, b_rd_addr;
  esna_ctl_t     f_ctl, b_ctl;
  logic [7:0]    b_pixel;
  logic [QW-1:0] q_in, q_out;

  esna_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .ROW_SLOTS (ROW_SLOTS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .pixel       (in_tdata),
    .frame_start (in_tuser),
    .image_width (image_width_r),
    .shift_x     (shift_x_r),
    .shift_y     (shift_y_r),
    .q_ready     (q_not_full),
    .push        (push),
    .wr_addr     (f_wr_addr),
    .rd_addr     (f_rd_addr),
    .ctl         (f_ctl)
  );

  // queue between front and back: each side stalls on its own
  assign q_in = {f_wr_addr, f_rd_addr, in_tdata, f_ctl};

  esna_queue #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_in),
    .not_full  (q_not_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head_data (q_out)
  );

  assign {b_wr_addr, b_rd_addr, b_pixel, b_ctl} = q_out;

  // back: row store access, averaging and output register
  esna_back #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_not_empty),
    .pop         (pop),
    .wr_addr     (b_wr_addr),
    .rd_addr     (b_rd_addr),
    .pixel       (b_pixel),
    .ctl         (b_ctl),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .embossed    (out_tdata),
    .frame_first (out_tuser)
  );

endmodule

`default_nettype wire

### rtl/esna_checker.sv
`default_nettype none

`include "emboss_shifted_negative_average_core_macros.svh"

module esna_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tuser
);

  // beats accepted but not yet delivered
  logic [3:0] cnt_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_r <= cnt_r + 4'd1;
    end else if (out_acc && !in_acc) begin
      cnt_r <= cnt_r - 4'd1;
    end
  end

  `ESNA_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_tvalid, "out_tvalid after reset")
  `ESNA_ASSERT(a_hold_valid, out_tvalid && !out_tready |=> out_tvalid, "out_tvalid dropped")
  `ESNA_ASSERT(a_hold_data, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser), "stalled beat changed")
  `ESNA_ASSERT(a_no_phantom, out_tvalid |-> cnt_r != 4'd0, "result with no input pending")
  `ESNA_ASSERT(a_capacity, cnt_r <= 4'd6, "more beats in flight than storage")

endmodule

bind emboss_shifted_negative_average_core esna_checker u_esna_checker (.*);

`default_nettype wire
